@@ src/lfu_cache_with_lru_tiebreak_unit_assert.svh @@
// Assertion macros used by the checker file lfu_chk.sv
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_UNIT_ASSERT_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_UNIT_ASSERT_SVH

// clocked check, off while reset is asserted
`define LFU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lfu check failed");

// clocked check that also holds during reset
`define LFU_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("lfu check failed");

`endif

@@ src/lfu_pkg.sv @@
// Shared types and constants for the LFU cache
`timescale 1ns / 1ps
package lfu_pkg;
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [VAL_W-1:0] VAL_MISS = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_TOUCH,
		OP_FILL,
		OP_EVICT
	} op_t;
endpackage

@@ src/lfu_cell.sv @@
// One cache slot: holds an entry, folds it into the passing search request
`timescale 1ns / 1ps
module lfu_cell import lfu_pkg::*; #(
	parameter int IDX_W = 4,
	parameter int COUNT_BITS = 16,
	parameter int CELL_IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [KEY_W-1:0]      key,
	input  logic                  tin_vld,
	input  logic                  tin_found,
	input  logic [IDX_W-1:0]      tin_fslot,
	input  logic [VAL_W-1:0]      tin_fdata,
	input  logic [IDX_W-1:0]      tin_frank,
	input  logic                  tin_gfree,
	input  logic [IDX_W-1:0]      tin_free,
	input  logic                  tin_gv,
	input  logic [IDX_W-1:0]      tin_vslot,
	input  logic [COUNT_BITS-1:0] tin_vcnt,
	input  logic [IDX_W-1:0]      tin_vrank,
	output logic                  tout_vld,
	output logic                  tout_found,
	output logic [IDX_W-1:0]      tout_fslot,
	output logic [VAL_W-1:0]      tout_fdata,
	output logic [IDX_W-1:0]      tout_frank,
	output logic                  tout_gfree,
	output logic [IDX_W-1:0]      tout_free,
	output logic                  tout_gv,
	output logic [IDX_W-1:0]      tout_vslot,
	output logic [COUNT_BITS-1:0] tout_vcnt,
	output logic [IDX_W-1:0]      tout_vrank,
	input  op_t                   cmd_op,
	input  logic [IDX_W-1:0]      cmd_slot,
	input  logic [IDX_W-1:0]      cmd_rank,
	input  logic [KEY_W-1:0]      cmd_key,
	input  logic [VAL_W-1:0]      cmd_data,
	input  logic                  cmd_wr
);
	localparam logic [IDX_W-1:0] ME = IDX_W'(CELL_IDX);

	logic                  valid_q;
	logic [KEY_W-1:0]      key_q;
	logic [VAL_W-1:0]      data_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [IDX_W-1:0]      rank_q;
	logic match, take_free, take_v, sel;

	assign match = valid_q && (key_q == key);
	assign take_free = !tin_gfree && !valid_q;
	assign take_v = valid_q && (!tin_gv || cnt_q < tin_vcnt ||
		(cnt_q == tin_vcnt && rank_q > tin_vrank));
	assign sel = (cmd_slot == ME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout_vld <= 1'b0;
		end else begin
			tout_vld <= tin_vld;
		end
	end

	always_ff @(posedge clk) begin
		tout_found <= tin_found || match;
		tout_fslot <= (!tin_found && match) ? ME : tin_fslot;
		tout_fdata <= (!tin_found && match) ? data_q : tin_fdata;
		tout_frank <= (!tin_found && match) ? rank_q : tin_frank;
		tout_gfree <= tin_gfree || take_free;
		tout_free  <= take_free ? ME : tin_free;
		tout_gv    <= tin_gv || take_v;
		tout_vslot <= take_v ? ME : tin_vslot;
		tout_vcnt  <= take_v ? cnt_q : tin_vcnt;
		tout_vrank <= take_v ? rank_q : tin_vrank;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if ((cmd_op == OP_FILL || cmd_op == OP_EVICT) && sel) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd_op)
			OP_TOUCH: begin
				if (sel) begin
					rank_q <= '0;
					if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
					if (cmd_wr) data_q <= cmd_data;
				end else if (valid_q && rank_q < cmd_rank) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			OP_FILL, OP_EVICT: begin
				if (sel) begin
					key_q  <= cmd_key;
					data_q <= cmd_data;
					cnt_q  <= COUNT_BITS'(1);
					rank_q <= '0;
				end else if (valid_q && (cmd_op == OP_FILL || rank_q < cmd_rank)) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

@@ src/lfu_cache_with_lru_tiebreak_unit.sv @@
// LFU cache top level: request control and the row of slot cells.
// The search walks the cell row one slot a cycle. A request is taken only in the idle
// state, after the last result has moved to the output register.
// A new request is taken while a finished result still waits on the output register.
// Reset (arst_n, async low) empties the cache and sets capacity to 16.
`timescale 1ns / 1ps
module lfu_cache_with_lru_tiebreak_unit import lfu_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,   // key[30:0], value[62:31], zero pad
	input  logic             s_tuser,   // func (0 get, 1 put)
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,   // read_value[31:0]
	output logic             m_tuser    // hit
);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FW = $clog2(ENTRIES + 1);
	localparam int CW = (FW > CAP_W) ? FW : CAP_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE} state_t;
	state_t state_q;

	logic [CAP_W-1:0] cap_q;
	logic [FW-1:0] filled_q;
	logic func_q, start_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic res_hit_q;
	logic [VAL_W-1:0] res_data_q;

	logic                  t_vld   [ENTRIES+1];
	logic                  t_found [ENTRIES+1];
	logic [IDX_W-1:0]      t_fslot [ENTRIES+1];
	logic [VAL_W-1:0]      t_fdata [ENTRIES+1];
	logic [IDX_W-1:0]      t_frank [ENTRIES+1];
	logic                  t_gfree [ENTRIES+1];
	logic [IDX_W-1:0]      t_free  [ENTRIES+1];
	logic                  t_gv    [ENTRIES+1];
	logic [IDX_W-1:0]      t_vslot [ENTRIES+1];
	logic [COUNT_BITS-1:0] t_vcnt  [ENTRIES+1];
	logic [IDX_W-1:0]      t_vrank [ENTRIES+1];

	op_t cmd_op;
	logic [IDX_W-1:0] cmd_slot, cmd_rank;
	logic out_free, commit, room, emit;
	logic [CW-1:0] eff_cap;

	assign t_vld[0] = start_q;
	assign t_found[0] = 1'b0;
	assign t_fslot[0] = '0;
	assign t_fdata[0] = '0;
	assign t_frank[0] = '0;
	assign t_gfree[0] = 1'b0;
	assign t_free[0] = '0;
	assign t_gv[0] = 1'b0;
	assign t_vslot[0] = '0;
	assign t_vcnt[0] = '0;
	assign t_vrank[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lfu_cell #(.IDX_W(IDX_W), .COUNT_BITS(COUNT_BITS), .CELL_IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .key(key_q),
			.tin_vld(t_vld[i]), .tin_found(t_found[i]), .tin_fslot(t_fslot[i]),
			.tin_fdata(t_fdata[i]), .tin_frank(t_frank[i]), .tin_gfree(t_gfree[i]),
			.tin_free(t_free[i]), .tin_gv(t_gv[i]), .tin_vslot(t_vslot[i]),
			.tin_vcnt(t_vcnt[i]), .tin_vrank(t_vrank[i]),
			.tout_vld(t_vld[i+1]), .tout_found(t_found[i+1]), .tout_fslot(t_fslot[i+1]),
			.tout_fdata(t_fdata[i+1]), .tout_frank(t_frank[i+1]),
			.tout_gfree(t_gfree[i+1]), .tout_free(t_free[i+1]), .tout_gv(t_gv[i+1]),
			.tout_vslot(t_vslot[i+1]), .tout_vcnt(t_vcnt[i+1]),
			.tout_vrank(t_vrank[i+1]),
			.cmd_op(cmd_op), .cmd_slot(cmd_slot), .cmd_rank(cmd_rank),
			.cmd_key(key_q), .cmd_data(value_q), .cmd_wr(func_q)
		);
	end

	// capacity clamped to 1..ENTRIES
	always_comb begin
		if (cap_q == '0) eff_cap = CW'(1);
		else if (CW'(cap_q) > CW'(ENTRIES)) eff_cap = CW'(ENTRIES);
		else eff_cap = CW'(cap_q);
	end

	assign room = CW'(filled_q) < eff_cap;
	assign out_free = !m_tvalid || m_tready;
	// search front leaves the last cell for one cycle only
	assign commit = (state_q == ST_SCAN) && t_vld[ENTRIES];
	assign emit = (state_q == ST_WRITE) && out_free;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd_op = OP_NONE;
		cmd_slot = t_fslot[ENTRIES];
		cmd_rank = t_frank[ENTRIES];
		if (commit) begin
			if (t_found[ENTRIES]) begin
				cmd_op = OP_TOUCH;
			end else if (func_q && room && t_gfree[ENTRIES]) begin
				cmd_op = OP_FILL;
				cmd_slot = t_free[ENTRIES];
			end else if (func_q && !room && t_gv[ENTRIES]) begin
				cmd_op = OP_EVICT;
				cmd_slot = t_vslot[ENTRIES];
				cmd_rank = t_vrank[ENTRIES];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q  <= s_tuser;
			key_q   <= s_tdata[KEY_W-1:0];
			value_q <= s_tdata[KEY_W+VAL_W-1:KEY_W];
		end
		if (commit) begin
			res_hit_q  <= t_found[ENTRIES];
			res_data_q <= (t_found[ENTRIES] && !func_q) ? t_fdata[ENTRIES] : VAL_MISS;
		end
		if (emit) begin
			m_tuser <= res_hit_q;
			m_tdata <= res_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			start_q  <= 1'b0;
			cap_q    <= CAP_RESET;
			filled_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			start_q <= s_tvalid && s_tready;
			if (cfg_we) cap_q <= cfg_wdata;
			if (emit) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (t_vld[ENTRIES]) begin
						state_q <= ST_WRITE;
						if (cmd_op == OP_FILL) filled_q <= filled_q + 1'b1;
					end
				end
				ST_WRITE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ src/lfu_chk.sv @@
// Port-level checks for the LFU cache, bound to the top level
`timescale 1ns / 1ps
`include "lfu_cache_with_lru_tiebreak_unit_assert.svh"
module lfu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	// one request in flight: ready drops right after an accept
	`LFU_ASSERT(a_one_inflight, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)
	// a result never appears the cycle after its request
	`LFU_ASSERT(a_no_instant, clk, arst_n, $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
	// misses read back all ones (puts also return all ones, but this check covers misses only)
	`LFU_ASSERT(a_miss_val, clk, arst_n, (m_tvalid && !m_tuser) |-> (m_tdata == 32'hFFFF_FFFF))
	`LFU_ASSERT(a_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
	`LFU_ASSERT_NR(a_rst_out, clk, !arst_n |-> !m_tvalid)
endmodule

bind lfu_cache_with_lru_tiebreak_unit lfu_chk u_lfu_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);
